// File: design/xcaf_pkg.sv
package xcaf_pkg;

    localparam int SeqMaxDigits = 5;

    typedef logic [15:0] t_seq;
    typedef logic [7:0]  t_byte;
    typedef logic [3:0]  t_nibble;

    localparam t_byte SohByte   = 8'h01;
    localparam t_byte BarByte   = 8'h7C;
    localparam t_byte CrByte    = 8'h0D;
    localparam t_byte LfByte    = 8'h0A;
    localparam t_byte ChC       = 8'h43;
    localparam t_byte ChM       = 8'h4D;
    localparam t_byte ChD       = 8'h44;
    localparam t_byte ZeroChar  = 8'h30;
    localparam t_byte HexAlpha  = 8'h37;
    localparam t_nibble DecBase = 4'd10;

    typedef enum logic [3:0] {
        P_SOH,
        P_CH_C,
        P_CH_M,
        P_CH_D,
        P_BAR1,
        P_DIGIT,
        P_BAR2,
        P_DATA,
        P_TBAR,
        P_HEX_HI,
        P_HEX_LO,
        P_CR,
        P_LF
    } t_phase;

    typedef struct packed {
        logic load;
        logic step;
        logic pop;
    } t_dig_ctrl;

    typedef struct packed {
        logic    nonempty;
        logic    last;
        t_nibble digit;
    } t_dig_stat;

    // Exact quotient by ten for any 16-bit value.
    function automatic t_seq div10(input t_seq v);
        logic [31:0] p;
        p = 32'(v) * 32'h0000_CCCD;
        return t_seq'(p[31:19]);
    endfunction

    function automatic t_byte hex_char(input t_nibble n);
        t_byte b;
        b = (n < DecBase) ? (ZeroChar + {4'h0, n}) : (HexAlpha + {4'h0, n});
        return b;
    endfunction

endpackage

// File: design/xcaf_in_if.sv
interface xcaf_in_if;
    logic            valid;
    logic            ready;
    xcaf_pkg::t_seq  seq_number;
    xcaf_pkg::t_byte payload_byte;
    logic            payload_end;

    modport source (output valid, output seq_number, output payload_byte,
                    output payload_end, input ready);
    modport sink   (input valid, input seq_number, input payload_byte,
                    input payload_end, output ready);
endinterface

// File: design/xcaf_out_if.sv
interface xcaf_out_if;
    logic            valid;
    logic            ready;
    xcaf_pkg::t_byte frame_byte;
    logic            frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

// File: design/xor_checksum_ascii_framer_unit.sv
// A payload word is held in the input register and then in the output register.
// Throughput: unless o_out.ready stalls, one output word and one middle payload word per cycle.
// The first word of a frame expands to 7 + k output words (k = sequence digits), and
// the last word adds 5 more, so the input stalls for those runs.
// Reset is synchronous and active low; it clears the sequencer, valids and checksum.
module xor_checksum_ascii_framer_unit #(
    parameter int SEQ_DIGITS = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xcaf_in_if.sink    i_in,
    xcaf_out_if.source o_out
);
    import xcaf_pkg::*;

    localparam int NumDigits = (SEQ_DIGITS < SeqMaxDigits) ? SEQ_DIGITS : SeqMaxDigits;

    logic      r_in_valid;
    t_seq      r_in_seq;
    t_byte     r_in_byte;
    logic      r_in_end;

    t_phase    r_phase;
    t_phase    n_phase;
    t_byte     r_xor;
    t_byte     n_xor;

    logic      r_out_valid;
    t_byte     r_out_byte;
    logic      r_out_last;

    logic      w_advance;
    logic      w_emit;
    t_byte     w_byte;
    logic      w_last;
    logic      w_consume;
    t_dig_ctrl w_dig_ctrl;
    t_dig_stat w_dig_stat;

    xcaf_digits #(
        .NUM_DIGITS (NumDigits)
    ) u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seq   (r_in_seq),
        .i_ctrl  (w_dig_ctrl),
        .o_stat  (w_dig_stat)
    );

    assign w_advance = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_seq  <= i_in.seq_number;
            r_in_byte <= i_in.payload_byte;
            r_in_end  <= i_in.payload_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_SOH;
            r_xor   <= '0;
        end else begin
            r_phase <= n_phase;
            r_xor   <= n_xor;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_xor      = r_xor;
        w_emit     = 1'b0;
        w_byte     = '0;
        w_last     = 1'b0;
        w_consume  = 1'b0;
        w_dig_ctrl = '0;
        if (w_advance) begin
            case (r_phase)
                P_SOH: begin
                    if (r_in_valid) begin
                        w_emit          = 1'b1;
                        w_byte          = SohByte;
                        w_dig_ctrl.load = 1'b1;
                        n_phase         = P_CH_C;
                    end
                end
                P_CH_C: begin
                    w_emit          = 1'b1;
                    w_byte          = ChC;
                    w_dig_ctrl.step = 1'b1;
                    n_phase         = P_CH_M;
                end
                P_CH_M: begin
                    w_emit          = 1'b1;
                    w_byte          = ChM;
                    w_dig_ctrl.step = 1'b1;
                    n_phase         = P_CH_D;
                end
                P_CH_D: begin
                    w_emit          = 1'b1;
                    w_byte          = ChD;
                    w_dig_ctrl.step = 1'b1;
                    n_phase         = P_BAR1;
                end
                P_BAR1: begin
                    w_emit          = 1'b1;
                    w_byte          = BarByte;
                    w_dig_ctrl.step = 1'b1;
                    n_phase         = P_DIGIT;
                end
                P_DIGIT: begin
                    w_emit         = 1'b1;
                    w_byte         = ZeroChar + {4'h0, w_dig_stat.digit};
                    w_dig_ctrl.pop = 1'b1;
                    if (w_dig_stat.last) begin
                        n_phase = P_BAR2;
                    end
                end
                P_BAR2: begin
                    w_emit  = 1'b1;
                    w_byte  = BarByte;
                    n_phase = P_DATA;
                end
                P_DATA: begin
                    if (r_in_valid) begin
                        w_emit    = 1'b1;
                        w_byte    = r_in_byte;
                        w_consume = 1'b1;
                        if (r_in_end) begin
                            n_phase = P_TBAR;
                        end
                    end
                end
                P_TBAR: begin
                    w_emit  = 1'b1;
                    w_byte  = BarByte;
                    n_phase = P_HEX_HI;
                end
                P_HEX_HI: begin
                    w_emit  = 1'b1;
                    w_byte  = hex_char(r_xor[7:4]);
                    n_phase = P_HEX_LO;
                end
                P_HEX_LO: begin
                    w_emit  = 1'b1;
                    w_byte  = hex_char(r_xor[3:0]);
                    n_phase = P_CR;
                end
                P_CR: begin
                    w_emit  = 1'b1;
                    w_byte  = CrByte;
                    n_phase = P_LF;
                end
                P_LF: begin
                    w_emit  = 1'b1;
                    w_byte  = LfByte;
                    w_last  = 1'b1;
                    n_phase = P_SOH;
                end
                default: begin
                    n_phase = P_SOH;
                end
            endcase
            // Every word from the command letters through the payload enters the checksum.
            if (w_emit && (r_phase != P_SOH) && (r_phase != P_TBAR)
                    && (r_phase != P_HEX_HI) && (r_phase != P_HEX_LO)
                    && (r_phase != P_CR) && (r_phase != P_LF)) begin
                n_xor = r_xor ^ w_byte;
            end
            if (r_phase == P_LF) begin
                n_xor = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_byte <= w_byte;
            r_out_last <= w_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.frame_byte = r_out_byte;
    assign o_out.frame_last = r_out_last;

`ifndef SYNTHESIS
    a_last_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_last) |-> (o_out.frame_byte == LfByte))
        else $error("frame_last set on a word other than LF");

    a_consume_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_consume |-> ((r_phase == P_DATA) && r_in_valid && w_advance))
        else $error("input word consumed outside the payload phase");

    a_frame_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == P_LF) && w_advance) |=> ((r_phase == P_SOH) && (r_xor == '0)))
        else $error("frame did not close cleanly after LF");

    a_digit_available: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_DIGIT) |-> w_dig_stat.nonempty)
        else $error("sequence digit phase entered with no digits stored");

    a_header_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase != P_SOH) && (r_phase != P_DATA) && (r_phase != P_TBAR)
            && (r_phase != P_HEX_HI) && (r_phase != P_HEX_LO) && (r_phase != P_CR)
            && (r_phase != P_LF)) |-> r_in_valid)
        else $error("first payload word lost during the header");
`endif

endmodule

// File: design/xcaf_digits.sv
module xcaf_digits #(
    parameter int NUM_DIGITS = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  xcaf_pkg::t_seq      i_seq,
    input  xcaf_pkg::t_dig_ctrl i_ctrl,
    output xcaf_pkg::t_dig_stat o_stat
);
    import xcaf_pkg::*;

    localparam int CntW = $clog2(NUM_DIGITS + 1);
    localparam int IdxW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    t_nibble         r_dig [NUM_DIGITS];
    t_seq            r_val;
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] n_cnt;
    logic [CntW-1:0] w_top;
    t_seq            w_src;
    t_seq            w_quot;
    t_seq            w_rem;
    logic            w_more;

    // One decimal digit is peeled off per cycle of load or step, least significant first.
    always_comb begin
        w_src  = i_ctrl.load ? i_seq : r_val;
        w_quot = div10(w_src);
        w_rem  = w_src - ((w_quot << 3) + (w_quot << 1));
        w_more = (r_val != '0) && (r_cnt < CntW'(NUM_DIGITS));
        w_top  = r_cnt - CntW'(1);
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_ctrl.load) begin
            n_cnt = CntW'(1);
        end else if (i_ctrl.step && w_more) begin
            n_cnt = r_cnt + CntW'(1);
        end else if (i_ctrl.pop && (r_cnt != '0)) begin
            n_cnt = w_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_val    <= w_quot;
            r_dig[0] <= w_rem[3:0];
        end else if (i_ctrl.step && w_more) begin
            r_val                   <= w_quot;
            r_dig[r_cnt[IdxW-1:0]]  <= w_rem[3:0];
        end
    end

    assign o_stat.nonempty = (r_cnt != '0);
    assign o_stat.last     = (r_cnt == CntW'(1));
    assign o_stat.digit    = (r_cnt != '0) ? r_dig[w_top[IdxW-1:0]] : '0;

endmodule

// File: tb/sv/tb.sv
module tb;
    import xcaf_pkg::*;

    localparam int NumDirRows = 17;
    localparam int RandWords = 200;
    localparam int CalmAfter = 160;
    localparam int CycleLimit = 500000;

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_fword;

    typedef struct {
        t_seq  seq;
        t_byte data;
        bit    fin;
        string text;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    xcaf_in_if  in_if ();
    xcaf_out_if out_if ();

    xor_checksum_ascii_framer_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_fword frame_words_due[$];
    t_fword predicted[$];
    bit     in_frame;
    t_byte  frame_xor;
    bit     send_idle;
    bit     recv_idle;
    int     mismatches;
    int     words_sent;
    int     words_checked;
    int     frames_closed;
    int     cycles;

    // Single-byte frames, a two-word frame with an ignored sequence number inside it,
    // and a bar as payload are typed out; the other rows go through the predictor.
    t_dir_row dir_rows [NumDirRows] = '{
        '{16'd0,      "A",   1'b1, "CMD|0|A|3B"},
        '{16'd65535,  8'hFF, 1'b1, ""},
        '{16'd7,      "H",   1'b0, "CMD|7|H"},
        '{16'd999,    "I",   1'b1, "I|7C"},
        '{16'd42,     "|",   1'b1, "CMD|42|||30"},
        '{16'd10000,  8'h00, 1'b0, ""},
        '{16'd65535,  8'h80, 1'b0, ""},
        '{16'd0,      8'h7F, 1'b0, ""},
        '{16'd1,      8'h01, 1'b0, ""},
        '{16'd2,      8'h0D, 1'b0, ""},
        '{16'd3,      8'h0A, 1'b1, ""},
        '{16'd9,      8'h55, 1'b1, ""},
        '{16'd10,     8'hAA, 1'b1, ""},
        '{16'd32768,  8'h0F, 1'b1, ""},
        '{16'h5555,   8'hF0, 1'b0, ""},
        '{16'hAAAA,   "Z",   1'b1, ""},
        '{16'd100,    8'h00, 1'b1, ""}
    };

    function automatic t_byte hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? ZeroChar + t_byte'(n) : t_byte'("A") + t_byte'(n) - 8'd10;
    endfunction

    function automatic void emit_plain(input t_byte b, input logic last);
        predicted.push_back('{b, last});
    endfunction

    function automatic void emit_summed(input t_byte b);
        frame_xor = frame_xor ^ b;
        predicted.push_back('{b, 1'b0});
    endfunction

    function automatic void predict_frame_words(input t_seq seq, input t_byte data,
                                                input bit fin);
        int    digs [SeqMaxDigits];
        int    cnt;
        int    v;
        t_byte sum;
        predicted.delete();
        if (!in_frame) begin
            frame_xor = '0;
            emit_plain(SohByte, 1'b0);
            emit_summed(ChC);
            emit_summed(ChM);
            emit_summed(ChD);
            emit_summed(BarByte);
            v = int'(seq);
            cnt = 0;
            do begin
                digs[cnt] = v % 10;
                v = v / 10;
                cnt++;
            end while (v != 0 && cnt < SeqMaxDigits);
            for (int i = cnt - 1; i >= 0; i--) emit_summed(ZeroChar + t_byte'(digs[i]));
            emit_summed(BarByte);
            in_frame = 1'b1;
        end
        emit_summed(data);
        if (fin) begin
            sum = frame_xor;
            emit_plain(BarByte, 1'b0);
            emit_plain(hex_digit(sum[7:4]), 1'b0);
            emit_plain(hex_digit(sum[3:0]), 1'b0);
            emit_plain(CrByte, 1'b0);
            emit_plain(LfByte, 1'b1);
            in_frame = 1'b0;
            frame_xor = '0;
        end
    endfunction

    task automatic send_word(input t_seq seq, input t_byte data, input bit fin,
                             input string text);
        bit opens;
        if (send_idle && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.seq_number   <= seq;
        in_if.payload_byte <= data;
        in_if.payload_end  <= fin;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        opens = !in_frame;
        predict_frame_words(seq, data, fin);
        words_sent++;
        if (fin) frames_closed++;
        if (text.len() == 0) begin
            foreach (predicted[i]) frame_words_due.push_back(predicted[i]);
        end else begin
            if (opens) frame_words_due.push_back('{SohByte, 1'b0});
            for (int i = 0; i < text.len(); i++) begin
                frame_words_due.push_back('{t_byte'(text[i]), 1'b0});
            end
            if (fin) begin
                frame_words_due.push_back('{CrByte, 1'b0});
                frame_words_due.push_back('{LfByte, 1'b1});
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Timed out after %0d cycles with %0d words outstanding.",
                     cycles, frame_words_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int     stall_left;
        t_fword want;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                if (frame_words_due.size() == 0) begin
                    $error("unexpected word: frame_byte %h frame_last %b",
                           out_if.frame_byte, out_if.frame_last);
                    mismatches++;
                end else begin
                    want = frame_words_due.pop_front();
                    words_checked++;
                    if (out_if.frame_byte !== want.data) begin
                        $error("frame_byte: expected %h, got %h", want.data, out_if.frame_byte);
                        mismatches++;
                    end
                    if (out_if.frame_last !== want.last) begin
                        $error("frame_last: expected %b, got %b", want.last, out_if.frame_last);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (recv_idle && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int   frame_len;
        int   rand_sent;
        t_seq seq;
        words_sent = 0;
        words_checked = 0;
        frames_closed = 0;
        in_frame = 1'b0;
        frame_xor = '0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        in_if.valid        <= 1'b0;
        in_if.seq_number   <= '0;
        in_if.payload_byte <= '0;
        in_if.payload_end  <= 1'b0;
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            send_word(dir_rows[r].seq, dir_rows[r].data, dir_rows[r].fin, dir_rows[r].text);
        end

        rand_sent = 0;
        while (rand_sent < RandWords) begin
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                    : $urandom_range(1, 6);
            case ($urandom_range(0, 5))
                0: seq = t_seq'($urandom_range(0, 9));
                1: seq = t_seq'($urandom_range(10, 99));
                2: seq = t_seq'($urandom_range(100, 9999));
                3: seq = 16'd65535;
                4: seq = 16'd0;
                default: seq = t_seq'($urandom_range(0, 65535));
            endcase
            for (int j = 0; j < frame_len; j++) begin
                if (rand_sent >= CalmAfter) begin
                    send_idle = 1'b0;
                    recv_idle = 1'b0;
                end
                send_word((j == 0) ? seq : t_seq'($urandom_range(0, 65535)),
                          t_byte'($urandom_range(0, 255)), j == frame_len - 1, "");
                rand_sent++;
            end
        end
        in_if.valid <= 1'b0;

        while (frame_words_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d payload words in %0d frames; checked %0d framed words.",
                 words_sent, frames_closed, words_checked);
        $display("Sequence numbers spanned one to five digits, with idle and stall bursts.");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
design/xcaf_pkg.sv
design/xcaf_in_if.sv
design/xcaf_out_if.sv
design/xcaf_digits.sv
design/xor_checksum_ascii_framer_unit.sv
tb/sv/tb.sv
